/* src/lfsp_pkg.sv */
// ----------------------------------------------------------------------------
// lfsp_pkg
// Shared types and constants for the line-follow steering block: register
// indexes, register reset values, the register bank and the stage record.
// ----------------------------------------------------------------------------
package lfsp_pkg;

  // Field widths fixed by the register map and the result format.
  localparam int THR_BITS       = 10;
  localparam int SPEED_BITS     = 8;
  localparam int GAIN_BITS      = 12;
  localparam int ERR_BITS       = 3;
  localparam int DELTA_BITS     = 4;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 12;

  // Register indexes on the configuration channel.
  localparam logic [CFG_INDEX_BITS-1:0] REG_MODE       = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_LEFT  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_RIGHT = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SLOW_SPEED = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_P     = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_I     = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_D     = 3'd7;

  // Steering mode codes.
  localparam logic MODE_BANG = 1'b0;
  localparam logic MODE_PID  = 1'b1;

  // Largest wheel speed.
  localparam logic [SPEED_BITS-1:0] SPEED_MAX = 8'd255;

  // Register bank.
  typedef struct packed {
    logic                  mode_select;
    logic [THR_BITS-1:0]   dark_level;
    logic [SPEED_BITS-1:0] base_left;
    logic [SPEED_BITS-1:0] base_right;
    logic [SPEED_BITS-1:0] slow_speed;
    logic [GAIN_BITS-1:0]  gain_p;
    logic [GAIN_BITS-1:0]  gain_i;
    logic [GAIN_BITS-1:0]  gain_d;
  } cfg_t;

  // Register values after reset (gains are Q8.4: 12.0, 0.0 and 5.0).
  localparam cfg_t CFG_RESET = '{
    mode_select:     MODE_PID,
    dark_level:      10'd700,
    base_left:       8'd80,
    base_right:      8'd74,
    slow_speed:      8'd15,
    gain_p:          12'd192,
    gain_i:          12'd0,
    gain_d:          12'd80
  };

  // What the error stage hands to the correction stage for one tick.
  typedef struct packed {
    logic                         pid;
    logic signed [ERR_BITS-1:0]   err;
    logic signed [DELTA_BITS-1:0] err_delta;
    logic [SPEED_BITS-1:0]        bang_left;
    logic [SPEED_BITS-1:0]        bang_right;
  } step_t;

endpackage

/* src/lfsp_error.sv */
// ----------------------------------------------------------------------------
// lfsp_error
// Sensor thresholding, position error, error sum update and bang-bang speeds
// for one tick. Purely combinational; the caller registers the results.
// ----------------------------------------------------------------------------
module lfsp_error #(
  parameter int SAMPLE_BITS = 10,
  parameter int SUM_BITS    = 24
) (
  input  lfsp_pkg::cfg_t                       cfg,
  input  logic [SAMPLE_BITS-1:0]               left_sample,
  input  logic [SAMPLE_BITS-1:0]               mid_sample,
  input  logic [SAMPLE_BITS-1:0]               right_sample,
  input  logic                                 restart,
  input  logic signed [lfsp_pkg::ERR_BITS-1:0] prev_error,
  input  logic signed [SUM_BITS-1:0]           error_sum,
  output lfsp_pkg::step_t                      step,
  output logic signed [lfsp_pkg::ERR_BITS-1:0] prev_error_next,
  output logic signed [SUM_BITS-1:0]           error_sum_next
);
  import lfsp_pkg::*;

  localparam int CMP_W = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

  // Sensor patterns, left sensor in the top bit.
  localparam logic [2:0] PAT_NONE       = 3'b000;
  localparam logic [2:0] PAT_RIGHT      = 3'b001;
  localparam logic [2:0] PAT_MID        = 3'b010;
  localparam logic [2:0] PAT_MID_RIGHT  = 3'b011;
  localparam logic [2:0] PAT_LEFT       = 3'b100;
  localparam logic [2:0] PAT_LEFT_MID   = 3'b110;

  logic                         on_l, on_m, on_r;
  logic [2:0]                   pattern;
  logic signed [ERR_BITS-1:0]   prev_eff;
  logic signed [SUM_BITS-1:0]   sum_eff;
  logic signed [ERR_BITS-1:0]   err;
  logic [SUM_BITS:0]            sum_wide;
  logic signed [SUM_BITS-1:0]   sum_sat;
  logic                         pid;

  // A sample strictly above the threshold sees the black line.
  assign on_l    = CMP_W'(left_sample)  > CMP_W'(cfg.dark_level);
  assign on_m    = CMP_W'(mid_sample)   > CMP_W'(cfg.dark_level);
  assign on_r    = CMP_W'(right_sample) > CMP_W'(cfg.dark_level);
  assign pattern = {on_l, on_m, on_r};
  assign pid     = (cfg.mode_select == MODE_PID);

  // Restart clears the loop state before this tick uses it.
  assign prev_eff = restart ? '0 : prev_error;
  assign sum_eff  = restart ? '0 : error_sum;

  // Position error; ambiguous patterns hold the previous error.
  always_comb begin
    unique case (pattern)
      PAT_LEFT:      err = -3'sd2;
      PAT_LEFT_MID:  err = -3'sd1;
      PAT_MID:       err = 3'sd0;
      PAT_MID_RIGHT: err = 3'sd1;
      PAT_RIGHT:     err = 3'sd2;
      PAT_NONE:      err = 3'sd0;
      default:       err = prev_eff;
    endcase
  end

  // Error sum with saturation at the signed limits of the accumulator.
  always_comb begin
    sum_wide = {sum_eff[SUM_BITS-1], sum_eff} + {{(SUM_BITS-2){err[ERR_BITS-1]}}, err};
    if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
      sum_sat = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                   : {1'b0, {(SUM_BITS-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_BITS-1:0];
    end
  end

  // Only PID mode advances the loop state.
  assign prev_error_next = pid ? err : prev_eff;
  assign error_sum_next  = pid ? sum_sat : sum_eff;

  // Bang-bang speeds; a black right sensor wins over a black left one.
  always_comb begin
    step.pid       = pid;
    step.err       = pid ? err : '0;
    step.err_delta = DELTA_BITS'(err) - DELTA_BITS'(prev_eff);
    if (on_r) begin
      step.bang_left  = cfg.base_left;
      step.bang_right = cfg.slow_speed;
    end else if (on_l) begin
      step.bang_left  = cfg.slow_speed;
      step.bang_right = cfg.base_right;
    end else begin
      step.bang_left  = cfg.base_left;
      step.bang_right = cfg.base_right;
    end
  end

endmodule

/* src/lfsp_drive.sv */
// ----------------------------------------------------------------------------
// lfsp_drive
// PID correction and wheel speed clamping for one tick. Combinational; the
// caller registers the speeds.
// ----------------------------------------------------------------------------
module lfsp_drive #(
  parameter int SUM_BITS = 24
) (
  input  lfsp_pkg::cfg_t                         cfg,
  input  lfsp_pkg::step_t                        step,
  input  logic signed [SUM_BITS-1:0]             error_sum,
  output logic [lfsp_pkg::SPEED_BITS-1:0]        left_speed,
  output logic [lfsp_pkg::SPEED_BITS-1:0]        right_speed,
  output logic signed [lfsp_pkg::ERR_BITS-1:0]   line_error
);
  import lfsp_pkg::*;

  localparam int PROD_P_W = GAIN_BITS + 1 + ERR_BITS;
  localparam int PROD_D_W = GAIN_BITS + 1 + DELTA_BITS;
  localparam int PROD_I_W = GAIN_BITS + 1 + SUM_BITS;
  localparam int CORR_W   = SUM_BITS + 16;

  logic signed [PROD_P_W-1:0] term_p;
  logic signed [PROD_D_W-1:0] term_d;
  logic signed [PROD_I_W-1:0] term_i;
  logic signed [CORR_W-1:0]   corr;
  logic signed [CORR_W-1:0]   left_val;
  logic signed [CORR_W-1:0]   right_val;

  // Q.4 value to wheel speed: negative gives zero, then drop the fraction
  // and clamp to the top speed.
  function automatic logic [SPEED_BITS-1:0] to_speed(input logic signed [CORR_W-1:0] v);
    logic [SPEED_BITS-1:0] s;
    if (v[CORR_W-1]) begin
      s = '0;
    end else if (|v[CORR_W-1:SPEED_BITS+4]) begin
      s = SPEED_MAX;
    end else begin
      s = v[SPEED_BITS+3:4];
    end
    return s;
  endfunction

  // Correction in Q.4 units; the gains are unsigned.
  assign term_p = $signed({1'b0, cfg.gain_p}) * $signed(step.err);
  assign term_d = $signed({1'b0, cfg.gain_d}) * $signed(step.err_delta);
  assign term_i = $signed({1'b0, cfg.gain_i}) * error_sum;
  assign corr   = CORR_W'(term_p) + CORR_W'(term_i) + CORR_W'(term_d);

  // Correction steers left up and right down.
  assign left_val  = CORR_W'($signed({1'b0, cfg.base_left, 4'b0000})) + corr;
  assign right_val = CORR_W'($signed({1'b0, cfg.base_right, 4'b0000})) - corr;

  // Result selection by mode.
  assign left_speed  = step.pid ? to_speed(left_val)  : step.bang_left;
  assign right_speed = step.pid ? to_speed(right_val) : step.bang_right;
  assign line_error  = step.err;

endmodule

/* src/line_follow_steering_pid.sv */
// ----------------------------------------------------------------------------
// line_follow_steering_pid
// Three-sensor line-follow steering with bang-bang or PID control.
// ----------------------------------------------------------------------------
// The block takes one sensor tick per clock cycle while results are taken
// and returns one pair of wheel speeds per tick: the error stage (threshold,
// position error and error sum, which is where the loop state is updated)
// works on the input register, the correction stage (three gain products and
// the speed clamp) works on the middle register, and the result then waits
// in the output register, where it is offered on the result side.
// Back-to-back ticks flow through at full rate as long as the result side
// takes them; a stalled result holds the pipeline. Setting restart on a tick
// clears the previous error and the error sum before that tick is used.
// Registers are written one per cycle on the configuration channel, which is
// always ready, and should only be written while no tick is in flight.
// ----------------------------------------------------------------------------
module line_follow_steering_pid #(
  parameter int SAMPLE_BITS = 10,
  parameter int SUM_BITS    = 24
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // Sensor tick stream.
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // left_sample, mid_sample, right_sample, zero padding
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // restart
  input  logic                                    s_axis_tuser,
  // Wheel speed stream.
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // left_speed, right_speed, line_error, zero padding
  output logic [23:0]                             m_axis_tdata,
  // Register write channel.
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [lfsp_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [lfsp_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
  import lfsp_pkg::*;

  localparam int OUT_BITS = 2*SPEED_BITS + ERR_BITS;

  cfg_t                        cfg;

  logic                        in_v;
  logic [SAMPLE_BITS-1:0]      in_left, in_mid, in_right;
  logic                        in_restart;
  logic                        mid_v;
  step_t                       mid_step;
  logic                        out_v;
  logic [SPEED_BITS-1:0]       out_left, out_right;
  logic signed [ERR_BITS-1:0]  out_err;

  logic signed [ERR_BITS-1:0]  prev_error, prev_error_next;
  logic signed [SUM_BITS-1:0]  error_sum, error_sum_next;

  step_t                       step;
  logic [SPEED_BITS-1:0]       drv_left, drv_right;
  logic signed [ERR_BITS-1:0]  drv_err;

  logic                        out_ok, mid_ok, in_ok;

  // Register writes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:       cfg.mode_select <= cfg_data[0];
        REG_THRESHOLD:  cfg.dark_level  <= cfg_data[THR_BITS-1:0];
        REG_BASE_LEFT:  cfg.base_left   <= cfg_data[SPEED_BITS-1:0];
        REG_BASE_RIGHT: cfg.base_right  <= cfg_data[SPEED_BITS-1:0];
        REG_SLOW_SPEED: cfg.slow_speed  <= cfg_data[SPEED_BITS-1:0];
        REG_GAIN_P:     cfg.gain_p      <= cfg_data[GAIN_BITS-1:0];
        REG_GAIN_I:     cfg.gain_i      <= cfg_data[GAIN_BITS-1:0];
        REG_GAIN_D:     cfg.gain_d      <= cfg_data[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or its contents move on this cycle.
  assign out_ok        = !out_v || m_axis_tready;
  assign mid_ok        = !mid_v || out_ok;
  assign in_ok         = !in_v  || mid_ok;
  assign s_axis_tready = in_ok;

  // Error stage between the input register and the middle register.
  lfsp_error #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_BITS    (SUM_BITS)
  ) u_error (
    .cfg             (cfg),
    .left_sample     (in_left),
    .mid_sample      (in_mid),
    .right_sample    (in_right),
    .restart         (in_restart),
    .prev_error      (prev_error),
    .error_sum       (error_sum),
    .step            (step),
    .prev_error_next (prev_error_next),
    .error_sum_next  (error_sum_next)
  );

  // The loop state updates on the same edge the middle register loads, so
  // while a tick sits there error_sum holds the sum that tick produced.
  lfsp_drive #(
    .SUM_BITS (SUM_BITS)
  ) u_drive (
    .cfg         (cfg),
    .step        (mid_step),
    .error_sum   (error_sum),
    .left_speed  (drv_left),
    .right_speed (drv_right),
    .line_error  (drv_err)
  );

  // Stage valid bits and loop state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v       <= 1'b0;
      mid_v      <= 1'b0;
      out_v      <= 1'b0;
      prev_error <= '0;
      error_sum  <= '0;
    end else begin
      if (in_ok) begin
        in_v <= s_axis_tvalid;
      end
      if (mid_ok) begin
        mid_v <= in_v;
      end
      if (out_ok) begin
        out_v <= mid_v;
      end
      if (in_v && mid_ok) begin
        prev_error <= prev_error_next;
        error_sum  <= error_sum_next;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && in_ok) begin
      in_left    <= s_axis_tdata[SAMPLE_BITS-1:0];
      in_mid     <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
      in_right   <= s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
      in_restart <= s_axis_tuser;
    end
    if (in_v && mid_ok) begin
      mid_step <= step;
    end
    if (mid_v && out_ok) begin
      out_left  <= drv_left;
      out_right <= drv_right;
      out_err   <= drv_err;
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = {{(24-OUT_BITS){1'b0}}, out_err, out_right, out_left};

endmodule

/* src/lfsp_checker.sv */
// ----------------------------------------------------------------------------
// lfsp_checker
// Port-level checks for the line-follow steering block, bound to its top.
// ----------------------------------------------------------------------------
module lfsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // A result offered and not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // Input back-pressure only comes from a stalled result.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with the result side free");

  // The position error stays within -2..+2.
  a_err_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[18:16] != 3'b011 && m_axis_tdata[18:16] != 3'b100
                      && m_axis_tdata[18:16] != 3'b101)
    else $error("line error out of range");

endmodule

bind line_follow_steering_pid lfsp_checker u_lfsp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
